// ----- src/assert_macros.svh -----
// Assertion helpers for the conversion unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ----- src/e2q_pkg.sv -----
package e2q_pkg;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int MAX_STAGES = 24;
   localparam int CW = 33;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   function automatic logic [31:0] atan_turn32(input int i);
      case (i)
         0: return 32'h20000000;  1: return 32'h12E4051E;  2: return 32'h09FB385B;
         3: return 32'h051111D4;  4: return 32'h028B0D43;  5: return 32'h0145D7E1;
         6: return 32'h00A2F61E;  7: return 32'h00517C55;  8: return 32'h0028BE53;
         9: return 32'h00145F2F;  10: return 32'h000A2F98; 11: return 32'h000517CC;
         12: return 32'h00028BE6; 13: return 32'h000145F3; 14: return 32'h0000A2F9;
         15: return 32'h0000517C; 16: return 32'h000028BE; 17: return 32'h0000145F;
         18: return 32'h00000A2F; 19: return 32'h00000517; 20: return 32'h0000028B;
         21: return 32'h00000145; 22: return 32'h000000A2; 23: return 32'h00000051;
         default: return 32'h0;
      endcase
   endfunction

   function automatic logic [31:0] gain_q30(input int n);
      case (n)
         8: return 32'd652039508;  9: return 32'd652034533;  10: return 32'd652033289;
         11: return 32'd652032978; 12: return 32'd652032901; 13: return 32'd652032881;
         14: return 32'd652032876;
         default: return 32'd652032875;
      endcase
   endfunction

   function automatic logic [32:0] atan_scaled(input int i, input int ab);
      logic [32:0] r;
      r = ({1'b0, atan_turn32(i)} + (33'd1 << (31 - ab))) >> (32 - ab);
      return r;
   endfunction
endpackage

// ----- src/euler_to_quaternion_unit.sv -----
// Converts roll, pitch and yaw binary angles to a Q1.15 unit quaternion. The unit
// accepts one request every cycle while req_stall is low. Each request passes through
// the row of CORDIC cells, two multiply stages and the result buffer, with the sum
// and rounding done on the way into the buffer. The pipe never stops. Results wait
// in the buffer while the result side stalls, and the request side stalls only when
// the buffer could not take every request in flight.
`include "assert_macros.svh"
module euler_to_quaternion_unit #(
   parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF,
   parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  e2q_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output e2q_pkg::rsp_type rsp_data
);
   localparam int N = (CORDIC_STAGES < 8) ? 8 :
                      (CORDIC_STAGES > e2q_pkg::MAX_STAGES) ? e2q_pkg::MAX_STAGES :
                      CORDIC_STAGES;
   localparam int LAT = N + 2;
   localparam int CW = e2q_pkg::CW;

   // Free-running pipe with a skid buffer in front of the output.
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   logic signed [CW-1:0] cr, sr, cp, sp, cy, sy;
   logic [$clog2(LAT+3)-1:0] cnt_ff, cnt_in;
   logic [$clog2(LAT+3)-1:0] used;
   logic                     acc, pop;

   e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_r (
      .clock(clock), .angle(req_data.roll_angle), .cos_out(cr), .sin_out(sr));
   e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_p (
      .clock(clock), .angle(req_data.pitch_angle), .cos_out(cp), .sin_out(sp));
   e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_y (
      .clock(clock), .angle(req_data.yaw_angle), .cos_out(cy), .sin_out(sy));

   // Pairwise products: a = cr*cp, b = sr*sp, c = sr*cp, d = cr*sp, rounded to Q30.
   logic signed [2*CW-1:0] pa, pb, pc, pd;
   logic signed [CW-1:0] a_ff, b_ff, c_ff, d_ff, cy1_ff, sy1_ff;
   assign pa = 66'(cr) * 66'(cp);
   assign pb = 66'(sr) * 66'(sp);
   assign pc = 66'(sr) * 66'(cp);
   assign pd = 66'(cr) * 66'(sp);
   always_ff @(posedge clock) begin
      a_ff <= CW'((pa + (66'sd1 <<< 29)) >>> 30);
      b_ff <= CW'((pb + (66'sd1 <<< 29)) >>> 30);
      c_ff <= CW'((pc + (66'sd1 <<< 29)) >>> 30);
      d_ff <= CW'((pd + (66'sd1 <<< 29)) >>> 30);
      cy1_ff <= cy;
      sy1_ff <= sy;
   end

   logic signed [2*CW-1:0] acy_ff, bsy_ff, csy_ff, dcy_ff, ccy_ff, dsy_ff, asy_ff, bcy_ff;
   always_ff @(posedge clock) begin
      acy_ff <= 66'(a_ff) * 66'(cy1_ff);
      bsy_ff <= 66'(b_ff) * 66'(sy1_ff);
      ccy_ff <= 66'(c_ff) * 66'(cy1_ff);
      dsy_ff <= 66'(d_ff) * 66'(sy1_ff);
      dcy_ff <= 66'(d_ff) * 66'(cy1_ff);
      csy_ff <= 66'(c_ff) * 66'(sy1_ff);
      asy_ff <= 66'(a_ff) * 66'(sy1_ff);
      bcy_ff <= 66'(b_ff) * 66'(cy1_ff);
   end

   function automatic logic signed [15:0] to_q15(input logic signed [2*CW:0] v);
      logic signed [2*CW:0] r;
      r = (v + (67'sd1 <<< 44)) >>> 45;
      if (r > 67'sd32767) return 16'sh7fff;
      if (r < -67'sd32768) return 16'sh8000;
      return r[15:0];
   endfunction

   e2q_pkg::rsp_type res;
   assign res.quat_w = to_q15(67'(acy_ff) + 67'(bsy_ff));
   assign res.quat_x = to_q15(67'(ccy_ff) - 67'(dsy_ff));
   assign res.quat_y = to_q15(67'(dcy_ff) + 67'(csy_ff));
   assign res.quat_z = to_q15(67'(asy_ff) - 67'(bcy_ff));

   // Result FIFO, deep enough for every request in flight.
   localparam int FD = LAT + 2;
   localparam int AW = $clog2(FD);
   e2q_pkg::rsp_type fifo_ff [FD];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [$clog2(FD+1)-1:0] fc_ff;
   logic push;
   assign push = vld_ff[LAT-1];
   assign pop  = rsp_valid && !rsp_stall;
   assign rsp_valid = fc_ff != '0;
   assign rsp_data  = fifo_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push) fifo_ff[wp_ff] <= res;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         fc_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(FD-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(FD-1)) ? '0 : rp_ff + 1'b1;
         fc_ff <= fc_ff + ($bits(fc_ff))'(push) - ($bits(fc_ff))'(pop);
      end
   end

   // Credit count: requests in the pipe plus results held.
   assign used = cnt_ff;
   assign req_stall = used >= ($bits(used))'(FD);
   assign acc = req_valid && !req_stall;
   assign vld_in = {vld_ff[LAT-2:0], acc};
   assign cnt_in = cnt_ff + ($bits(cnt_ff))'(acc) - ($bits(cnt_ff))'(pop);
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   `ASSERT_IMPL(a_no_overflow, clock, reset, push, fc_ff < ($bits(fc_ff))'(FD))
   `ASSERT_IMPL(a_credit, clock, reset, 1'b1, cnt_ff >= ($bits(cnt_ff))'(fc_ff))
   `ASSERT_NEXT(a_pop_drops, clock, reset, pop && !push, fc_ff == $past(fc_ff) - 1'b1)
endmodule

// ----- src/e2q_cell.sv -----
module e2q_cell #(
   parameter int STAGE = 0,
   parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic signed [e2q_pkg::CW-1:0]   x_in,
   input  logic signed [e2q_pkg::CW-1:0]   y_in,
   input  logic signed [ANGLE_BITS:0]      z_in,
   output logic signed [e2q_pkg::CW-1:0]   x_ff,
   output logic signed [e2q_pkg::CW-1:0]   y_ff,
   output logic signed [ANGLE_BITS:0]      z_ff
);
   localparam logic [32:0] ATS = e2q_pkg::atan_scaled(STAGE, ANGLE_BITS);
   localparam logic signed [ANGLE_BITS:0] AT = ATS[ANGLE_BITS:0];
   logic signed [e2q_pkg::CW-1:0] dx, dy;
   assign dx = x_in >>> STAGE;
   assign dy = y_in >>> STAGE;
   always_ff @(posedge clock) begin
      if (!z_in[ANGLE_BITS]) begin
         x_ff <= x_in - dy;
         y_ff <= y_in + dx;
         z_ff <= z_in - AT;
      end else begin
         x_ff <= x_in + dy;
         y_ff <= y_in - dx;
         z_ff <= z_in + AT;
      end
   end
endmodule

// ----- src/e2q_cordic.sv -----
module e2q_cordic #(
   parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF,
   parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic signed [15:0]            angle,
   output logic signed [e2q_pkg::CW-1:0] cos_out,
   output logic signed [e2q_pkg::CW-1:0] sin_out
);
   localparam int N = (CORDIC_STAGES < 8) ? 8 :
                      (CORDIC_STAGES > e2q_pkg::MAX_STAGES) ? e2q_pkg::MAX_STAGES :
                      CORDIC_STAGES;
   localparam logic [31:0] K = e2q_pkg::gain_q30(N);
   logic signed [e2q_pkg::CW-1:0] xs [N+1];
   logic signed [e2q_pkg::CW-1:0] ys [N+1];
   logic signed [ANGLE_BITS:0]    zs [N+1];
   logic signed [ANGLE_BITS+16:0] wide;
   assign wide = {{(ANGLE_BITS+1){angle[15]}}, angle};
   assign xs[0] = e2q_pkg::CW'(K);
   assign ys[0] = '0;
   generate
      if (ANGLE_BITS >= 17) begin : g_up
         assign zs[0] = (ANGLE_BITS+1)'(wide <<< (ANGLE_BITS - 17));
      end else begin : g_dn
         assign zs[0] = (ANGLE_BITS+1)'(wide >>> (17 - ANGLE_BITS));
      end
   endgenerate
   for (genvar i = 0; i < N; i++) begin : g_cell
      e2q_cell #(.STAGE(i), .ANGLE_BITS(ANGLE_BITS)) u_cell (
         .clock(clock), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
         .x_ff(xs[i+1]), .y_ff(ys[i+1]), .z_ff(zs[i+1]));
   end
   assign cos_out = xs[N];
   assign sin_out = ys[N];
endmodule
